/* hw/rtl/afag_pkg.sv */
// Package for the AIMD admission gate: function and mode codes, register
// indexes and reset values, and the command/status structs between control and datapath.
// Standalone; imported by afag_ctrl, afag_dp and the top level.
package afag_pkg;

  // input word function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_CMPL  = 2'd1;
  localparam logic [1:0] FUNC_POLL  = 2'd2;
  localparam logic [1:0] FUNC_START = 2'd3;

  // cap modes
  localparam logic [1:0] MODE_BASE  = 2'd0;
  localparam logic [1:0] MODE_FIXED = 2'd1;
  localparam logic [1:0] MODE_AIMD  = 2'd2;
  localparam logic [1:0] MODE_OVR   = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_CAP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIENTS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE = 3'd4;

  // field widths
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned OVR_W      = 8;
  localparam int unsigned CLIENT_W   = 5;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned FIELD6_W   = 6;
  localparam int unsigned BUDGET_W   = 32;
  localparam int unsigned HOLD_W     = 3;

  // grants per poll limit and its counter width
  localparam int unsigned MAX_OUT = 32;
  localparam int unsigned NOUT_W  = 6;

  // register reset values
  localparam logic [1:0]          MODE_RST     = MODE_FIXED;
  localparam logic [FIELD6_W-1:0] INIT_CAP_RST = 6'd4;
  localparam logic [FIELD6_W-1:0] CLIENTS_RST  = 6'd32;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_TICK,
    OP_CMPL,
    OP_START,
    OP_GRANT,
    OP_EMPTY
  } op_t;

  typedef struct packed {
    logic accept;   // input word taken this cycle
    logic fill_wr;  // write one ring entry of the start sweep
    op_t  op;       // state update plus one result word
  } cmd_t;

  typedef struct packed {
    logic out_free;    // output register can take a word this cycle
    logic can_grant;   // poll may grant the head client now
    logic more_after;  // another grant would follow this one
    logic fill_last;   // sweep is at the last client
  } sts_t;

endpackage

/* hw/rtl/afag_ctrl.sv */
// Controller of the admission gate: sequences tick, completion, poll and start
// words and issues commands to afag_dp. Depends on afag_pkg.
module afag_ctrl import afag_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  output logic       in_stall,
  input  sts_t       sts,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_CMPL,
    S_FILL,
    S_START,
    S_POLL,
    S_POLL_WAIT
  } state_t;

  state_t state_r, state_nxt;

  // one word at a time: input is taken only in idle
  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd.accept  = 1'b0;
    cmd.fill_wr = 1'b0;
    cmd.op      = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (in_func)
            FUNC_TICK:  state_nxt = S_TICK;
            FUNC_CMPL:  state_nxt = S_CMPL;
            FUNC_POLL:  state_nxt = S_POLL;
            FUNC_START: state_nxt = S_FILL;
          endcase
        end
      end
      S_TICK: begin
        if (sts.out_free) begin
          cmd.op    = OP_TICK;
          state_nxt = S_IDLE;
        end
      end
      S_CMPL: begin
        if (sts.out_free) begin
          cmd.op    = OP_CMPL;
          state_nxt = S_IDLE;
        end
      end
      // write clients 0..count-1 into the ring, one a cycle
      S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (sts.fill_last) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (sts.out_free) begin
          cmd.op    = OP_START;
          state_nxt = S_IDLE;
        end
      end
      // one grant per pass; the wait lets the ring read catch up with the head
      S_POLL: begin
        if (sts.out_free) begin
          if (sts.can_grant) begin
            cmd.op    = OP_GRANT;
            state_nxt = sts.more_after ? S_POLL_WAIT : S_IDLE;
          end else begin
            cmd.op    = OP_EMPTY;
            state_nxt = S_IDLE;
          end
        end
      end
      S_POLL_WAIT: state_nxt = S_POLL;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/afag_dp.sv */
// Datapath of the admission gate: configuration registers, cap/hold/sum state,
// ready ring memory and the output word register. Depends on afag_pkg.
module afag_dp import afag_pkg::*; #(
  parameter int unsigned MAX_CLIENTS = 32,
  parameter int unsigned HOLD_TICKS  = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input word fields
  input  logic [SUM_W-1:0]      in_counter_sum,
  input  logic [OVR_W-1:0]      in_override_cap,
  input  logic [CLIENT_W-1:0]   in_client,
  input  logic [SLOT_W-1:0]     in_free_slots,
  // result word
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_kind,
  output logic [CLIENT_W-1:0]   out_granted_client,
  output logic [FIELD6_W-1:0]   out_current_cap,
  output logic [FIELD6_W-1:0]   out_in_flight,
  output logic [SUM_W-1:0]      out_loss_delta,
  output logic                  out_budget_done,
  output logic                  out_error,
  output logic                  out_last,
  // control
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  localparam int unsigned RING  = MAX_CLIENTS + 1;
  localparam int unsigned PTR_W = $clog2(RING);
  localparam int unsigned CNT_W = PTR_W;
  localparam int unsigned CAP_W = (CNT_W > FIELD6_W) ? CNT_W : FIELD6_W;

  localparam logic [PTR_W-1:0]    RING_LAST = PTR_W'(RING - 1);
  localparam logic [CAP_W-1:0]    CAP_MAX   = CAP_W'(MAX_CLIENTS);
  localparam logic [HOLD_W-1:0]   HOLD_LOAD = HOLD_W'(HOLD_TICKS);
  localparam logic [NOUT_W-1:0]   NOUT_MAX  = NOUT_W'(MAX_OUT);
  localparam logic [BUDGET_W-1:0] GRANT_SAT = '1;

  // configuration registers
  logic [1:0]          mode_r;
  logic [FIELD6_W-1:0] init_cap_r;
  logic [FIELD6_W-1:0] clients_r;
  logic [BUDGET_W-1:0] budget_r;
  logic [SUM_W-1:0]    baseline_r;

  // gate state
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0]    ifl_r, ifl_nxt;
  logic [CAP_W-1:0]    adapt_r, adapt_nxt;
  logic [HOLD_W-1:0]   hold_r, hold_nxt;
  logic [SUM_W-1:0]    prev_r, prev_nxt;
  logic [BUDGET_W-1:0] grants_r, grants_nxt;

  // per-word working registers
  logic [SUM_W-1:0]    sum_r;
  logic [SUM_W-1:0]    delta_r;
  logic [OVR_W-1:0]    ovr_r;
  logic [CLIENT_W-1:0] client_r;
  logic [SLOT_W-1:0]   slots_r;
  logic [NOUT_W-1:0]   nout_r;
  logic [PTR_W-1:0]    fill_r;

  // ring memory
  logic [CLIENT_W-1:0] ring_mem [RING];
  logic [CLIENT_W-1:0] rd_data_r;
  logic                mem_we;
  logic [PTR_W-1:0]    mem_wa;
  logic [CLIENT_W-1:0] mem_wd;

  // output register
  logic                out_valid_r;
  logic                kind_nxt, err_nxt, last_nxt, bdone_nxt;
  logic [CLIENT_W-1:0] who_nxt;
  logic [CAP_W-1:0]    cap_out;
  logic [SUM_W-1:0]    delta_out;

  // derived values
  logic [CAP_W-1:0]    ccount, scap, cap_now;
  logic [SUM_W-1:0]    delta_in;
  logic [OVR_W-1:0]    ovr_clamp;
  logic [CAP_W-1:0]    ifl_ext;
  logic [CAP_W:0]      ifl_inc;
  logic [PTR_W-1:0]    head_inc;
  logic [BUDGET_W-1:0] grants_inc;
  logic [NOUT_W-1:0]   nout_inc;
  logic [CAP_W-1:0]    fill_ext;
  logic [CAP_W-1:0]    ifl_out;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == RING_LAST) ? '0 : p + 1'b1;
    return r;
  endfunction

  function automatic logic [CAP_W-1:0] cap_sel(input logic [1:0] m,
                                               input logic [CAP_W-1:0] cnt,
                                               input logic [CAP_W-1:0] sc,
                                               input logic [CAP_W-1:0] ad);
    logic [CAP_W-1:0] r;
    unique case (m)
      MODE_BASE:  r = cnt;
      MODE_FIXED: r = sc;
      MODE_AIMD:  r = ad;
      MODE_OVR:   r = ad;
    endcase
    return r;
  endfunction

  function automatic logic budget_hit(input logic [BUDGET_W-1:0] g,
                                      input logic [BUDGET_W-1:0] b);
    return (b != '0) && (g >= b);
  endfunction

  assign cfg_ready = 1'b1;

  // client count clamped to 1..MAX_CLIENTS, start cap, cap in force
  always_comb begin
    if (clients_r == '0) begin
      ccount = CAP_W'(1);
    end else if (CAP_W'(clients_r) > CAP_MAX) begin
      ccount = CAP_MAX;
    end else begin
      ccount = CAP_W'(clients_r);
    end
    scap    = (init_cap_r != '0) ? CAP_W'(init_cap_r) : ccount;
    cap_now = cap_sel(mode_r, ccount, scap, adapt_r);
  end

  // counter increase against the recorded sum, taken with the word
  assign delta_in = (in_counter_sum >= prev_r) ? (in_counter_sum - prev_r) : '0;

  // override request clamped to the client count
  assign ovr_clamp = (ovr_r > OVR_W'(ccount)) ? OVR_W'(ccount) : ovr_r;

  assign ifl_ext    = CAP_W'(ifl_r);
  assign ifl_inc    = {1'b0, ifl_ext} + 1'b1;
  assign head_inc   = ptr_inc(head_r);
  assign grants_inc = (grants_r == GRANT_SAT) ? grants_r : grants_r + 1'b1;
  assign nout_inc   = nout_r + 1'b1;
  assign fill_ext   = CAP_W'(fill_r);

  // controller status
  always_comb begin
    sts.out_free  = !out_valid_r || !out_stall;
    sts.can_grant = (nout_r < NOUT_MAX) && (nout_r < NOUT_W'(slots_r)) &&
                    (ifl_ext < cap_now) && (head_r != tail_r) &&
                    !budget_hit(grants_r, budget_r);
    sts.more_after = (nout_inc < NOUT_MAX) && (nout_inc < NOUT_W'(slots_r)) &&
                     (ifl_inc < {1'b0, cap_now}) && (head_inc != tail_r) &&
                     !budget_hit(grants_inc, budget_r);
    sts.fill_last = (fill_ext == ccount - 1'b1);
  end

  // state update and result word for the current operation
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    ifl_nxt    = ifl_r;
    adapt_nxt  = adapt_r;
    hold_nxt   = hold_r;
    prev_nxt   = prev_r;
    grants_nxt = grants_r;
    kind_nxt   = 1'b0;
    who_nxt    = '0;
    err_nxt    = 1'b0;
    last_nxt   = 1'b1;
    delta_out  = '0;
    mem_we     = 1'b0;
    mem_wa     = fill_r;
    mem_wd     = fill_ext[CLIENT_W-1:0];
    unique case (cmd.op)
      OP_TICK: begin
        if (mode_r[1]) begin
          delta_out = delta_r;
          prev_nxt  = sum_r;
          if (mode_r == MODE_OVR) begin
            if (ovr_r != '0) begin
              adapt_nxt = CAP_W'(ovr_clamp);
            end
          end else if (delta_r != '0) begin
            adapt_nxt = (adapt_r > CAP_W'(1)) ? (adapt_r >> 1) : CAP_W'(1);
            hold_nxt  = HOLD_LOAD;
          end else if (hold_r != '0) begin
            hold_nxt = hold_r - 1'b1;
          end else if (adapt_r < ccount) begin
            adapt_nxt = adapt_r + 1'b1;
          end
        end
      end
      OP_CMPL: begin
        if (ifl_r == '0) begin
          err_nxt = 1'b1;
        end else begin
          ifl_nxt  = ifl_r - 1'b1;
          tail_nxt = ptr_inc(tail_r);
          mem_we   = 1'b1;
          mem_wa   = tail_r;
          mem_wd   = client_r;
        end
      end
      OP_START: begin
        head_nxt   = '0;
        tail_nxt   = ccount[PTR_W-1:0];
        ifl_nxt    = '0;
        grants_nxt = '0;
        hold_nxt   = '0;
        adapt_nxt  = scap;
        prev_nxt   = baseline_r;
      end
      OP_GRANT: begin
        kind_nxt   = 1'b1;
        who_nxt    = rd_data_r;
        head_nxt   = head_inc;
        ifl_nxt    = ifl_inc[CNT_W-1:0];
        grants_nxt = grants_inc;
        last_nxt   = !sts.more_after;
      end
      OP_EMPTY: begin
        kind_nxt = 1'b0;
      end
      default: begin
        kind_nxt = 1'b0;
      end
    endcase
    if (cmd.fill_wr) begin
      mem_we = 1'b1;
    end
    cap_out   = cap_sel(mode_r, ccount, scap, adapt_nxt);
    ifl_out   = CAP_W'(ifl_nxt);
    bdone_nxt = budget_hit(grants_nxt, budget_r);
  end

  // ring memory: one write port, registered read at the head
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= ring_mem[head_r];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_RST;
      init_cap_r <= INIT_CAP_RST;
      clients_r  <= CLIENTS_RST;
      budget_r   <= '0;
      baseline_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:     mode_r     <= cfg_data[1:0];
        CFG_INIT_CAP: init_cap_r <= cfg_data[FIELD6_W-1:0];
        CFG_CLIENTS:  clients_r  <= cfg_data[FIELD6_W-1:0];
        CFG_BUDGET:   budget_r   <= cfg_data[BUDGET_W-1:0];
        CFG_BASELINE: baseline_r <= cfg_data;
        default:      ;
      endcase
    end
  end

  // gate state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      ifl_r    <= '0;
      adapt_r  <= CAP_W'(INIT_CAP_RST);
      hold_r   <= '0;
      prev_r   <= '0;
      grants_r <= '0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      ifl_r    <= ifl_nxt;
      adapt_r  <= adapt_nxt;
      hold_r   <= hold_nxt;
      prev_r   <= prev_nxt;
      grants_r <= grants_nxt;
    end
  end

  // input word latch, poll grant count and fill sweep index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nout_r <= '0;
      fill_r <= '0;
    end else if (cmd.accept) begin
      nout_r <= '0;
      fill_r <= '0;
    end else begin
      if (cmd.op == OP_GRANT) begin
        nout_r <= nout_inc;
      end
      if (cmd.fill_wr) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sum_r    <= in_counter_sum;
      delta_r  <= delta_in;
      ovr_r    <= in_override_cap;
      client_r <= in_client;
      slots_r  <= in_free_slots;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op != OP_NONE) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op != OP_NONE) begin
      out_kind           <= kind_nxt;
      out_granted_client <= who_nxt;
      out_current_cap    <= cap_out[FIELD6_W-1:0];
      out_in_flight      <= ifl_out[FIELD6_W-1:0];
      out_loss_delta     <= delta_out;
      out_budget_done    <= bdone_nxt;
      out_error          <= err_nxt;
      out_last           <= last_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/aimd_fifo_admission_gate_unit.sv */
// Channel  | Direction | Handshake          | Word
// in_      | input     | in_valid/in_stall  | func, counter_sum, override_cap, client, free_slots
// out_     | output    | out_valid/out_stall| kind, granted_client, current_cap, in_flight,
//          |           |                    | loss_delta, budget_done, error, last
// cfg_     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Tick and completion words are accepted, then update the state and issue one result word.
// A poll issues one result word per grant, with a wait state before each further grant
// for the registered read port of the ready ring; a poll with no grant issues one word.
// A start word fills the ring one client per cycle, then issues its result word.
// Reset (rst_n low, synchronous) clears the queue, in-flight and grant counts and
// loads the register defaults. A stalled output holds its word; the next input word is
// taken once the current one has issued all its result words.
// Top level; instantiates afag_ctrl and afag_dp, depends on afag_pkg.
module aimd_fifo_admission_gate_unit import afag_pkg::*; #(
  parameter int unsigned MAX_CLIENTS = 32,
  parameter int unsigned HOLD_TICKS  = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input words
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_func,
  input  logic [SUM_W-1:0]      in_counter_sum,
  input  logic [OVR_W-1:0]      in_override_cap,
  input  logic [CLIENT_W-1:0]   in_client,
  input  logic [SLOT_W-1:0]     in_free_slots,
  // result words
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_kind,
  output logic [CLIENT_W-1:0]   out_granted_client,
  output logic [FIELD6_W-1:0]   out_current_cap,
  output logic [FIELD6_W-1:0]   out_in_flight,
  output logic [SUM_W-1:0]      out_loss_delta,
  output logic                  out_budget_done,
  output logic                  out_error,
  output logic                  out_last,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  afag_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  afag_dp #(
    .MAX_CLIENTS (MAX_CLIENTS),
    .HOLD_TICKS  (HOLD_TICKS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_counter_sum     (in_counter_sum),
    .in_override_cap    (in_override_cap),
    .in_client          (in_client),
    .in_free_slots      (in_free_slots),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_granted_client (out_granted_client),
    .out_current_cap    (out_current_cap),
    .out_in_flight      (out_in_flight),
    .out_loss_delta     (out_loss_delta),
    .out_budget_done    (out_budget_done),
    .out_error          (out_error),
    .out_last           (out_last),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule
